/* hw/rtl/pncm_pkg.sv */
// Shared types and constants for the nearest palette color match block.
`default_nettype none

package pncm_pkg;

  // Field widths
  localparam int unsigned COLOR_W = 32;
  localparam int unsigned IDX_W   = 8;
  localparam int unsigned DIST_W  = 18;
  localparam int unsigned SIZE_W  = 9;
  localparam int unsigned CHAN_W  = 8;

  // Stream packing widths
  localparam int unsigned S_DATA_W = 40;
  localparam int unsigned S_USER_W = 2;
  localparam int unsigned M_DATA_W = 64;

  // Distance bound for a qualifying entry and size register reset value
  localparam logic [DIST_W-1:0] DIST_LIMIT = 18'd200000;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

  // Request kinds
  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_MATCH = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  // Data handed from one distance cell to the next
  typedef struct packed {
    logic               valid;
    logic [IDX_W-1:0]   index;
    logic [COLOR_W-1:0] color;
    logic [DIST_W-1:0]  dist_sum;
  } cell_bus_t;

endpackage

`default_nettype wire

/* hw/rtl/pncm_ram.sv */
// Generic single-port-write, registered-read RAM.
`default_nettype none

module pncm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, hold data when idle
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hw/rtl/pncm_cell.sv */
// One distance cell: adds the squared difference of one color channel.
`default_nettype none

module pncm_cell
  import pncm_pkg::*;
#(
  parameter int unsigned SHIFT = 0
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [COLOR_W-1:0] query_i,
  input  wire cell_bus_t          cell_i,
  output cell_bus_t               cell_o
);

  logic [CHAN_W-1:0]   chan_p;
  logic [CHAN_W-1:0]   chan_q;
  logic [CHAN_W-1:0]   diff;
  logic [2*CHAN_W-1:0] sq;
  cell_bus_t           cell_d;
  cell_bus_t           cell_q;

  // Square the channel difference and add it to the running distance
  always_comb begin
    chan_p = cell_i.color[SHIFT +: CHAN_W];
    chan_q = query_i[SHIFT +: CHAN_W];
    diff   = (chan_p > chan_q) ? (chan_p - chan_q) : (chan_q - chan_p);
    sq     = diff * diff;
    cell_d = cell_i;
    cell_d.dist_sum = cell_i.dist_sum + DIST_W'(sq);
  end

  // Advance to the neighbor every cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

`default_nettype wire

/* hw/rtl/palette_nearest_color_match.sv */
// Top level of the nearest palette color match block.
//
// Usage: requests arrive on the s_axis channel, tuser carrying the request
// kind (load, match, read) and tdata the entry index and ARGB color. A load
// writes one palette entry and gives no result. A read returns the stored
// entry. A match streams the entries below the palette size through a row of
// four channel cells, one entry per cycle, and keeps the lowest index with
// the smallest squared distance below 200000. Results leave on m_axis.
// The palette size register is written through cfg_we_i / cfg_wdata_i; the
// user must write it only while the block is idle; the block does not enforce it.
// One request is handled at a time. During a match the palette RAM port
// delivers one entry per cycle into the cell row, which then drains through
// its four cells; a palette size of zero skips the scan.
// A new request is taken while a finished result waits in the output
// register; a further result holds until m_axis_tready takes the first.
// Reset clears control state and sets the palette size to 256; palette
// contents are undefined until loaded and no clearing pass is run.
`default_nettype none

module palette_nearest_color_match
  import pncm_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 256
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Configuration: palette_size
  input  wire logic                cfg_we_i,
  input  wire logic [SIZE_W-1:0]   cfg_wdata_i,
  // Request stream
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // tdata: entry_index [7:0], argb_color [39:8]
  input  wire logic [S_DATA_W-1:0] s_axis_tdata,
  // tuser: op [1:0]
  input  wire logic [S_USER_W-1:0] s_axis_tuser,
  // Result stream
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // tdata: best_index [7:0], found [8], best_distance [26:9],
  //        entry_color [58:27], zero [63:59]
  output logic [M_DATA_W-1:0]      m_axis_tdata
);

  localparam int unsigned AW    = $clog2(MAX_ENTRIES);
  localparam int unsigned CW    = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned NCELL = 4;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_DRAIN = 5'b00100,
    S_READ  = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [SIZE_W-1:0]  size_q;
  logic [COLOR_W-1:0] query_q;
  logic               is_match_q, is_match_d;
  logic               rd_oob_q, rd_oob_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic               rd_valid_q;
  logic [IDX_W-1:0]   rd_index_q;
  logic [COLOR_W-1:0] res_color_q;
  logic [DIST_W-1:0]  best_d_q;
  logic [IDX_W-1:0]   best_i_q;
  logic               hit_q;
  logic               m_valid_q;
  logic [M_DATA_W-1:0] m_data_q, m_data_d;

  logic               accept;
  op_e                op;
  logic [IDX_W-1:0]   in_idx;
  logic [COLOR_W-1:0] in_color;
  logic [31:0]        idx_ext;
  logic               idx_ok;
  logic [31:0]        size_ext;
  logic [CW-1:0]      limit;
  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [COLOR_W-1:0] ram_rdata;
  logic               issue;
  logic               start_match;
  logic               load_out;
  logic               chain_busy;
  cell_bus_t          chain [NCELL+1];

  // Unpack the request
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign op       = op_e'(s_axis_tuser);
  assign in_idx   = s_axis_tdata[IDX_W-1:0];
  assign in_color = s_axis_tdata[IDX_W +: COLOR_W];
  assign idx_ext  = 32'(in_idx);
  assign idx_ok   = idx_ext < 32'(MAX_ENTRIES);
  assign s_axis_tready = (state_q == S_IDLE);

  // Clamp the palette size to the store depth
  assign size_ext = 32'(size_q);
  assign limit    = (size_ext > 32'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) : CW'(size_ext);

  // Palette size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SIZE_RESET;
    end else if (cfg_we_i) begin
      size_q <= cfg_wdata_i;
    end
  end

  // Request decode and sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    is_match_d  = is_match_q;
    rd_oob_d    = rd_oob_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = idx_ext[AW-1:0];
    issue       = 1'b0;
    start_match = 1'b0;
    load_out    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (op)
            OP_LOAD: begin
              ram_we = idx_ok;
            end
            OP_MATCH: begin
              start_match = 1'b1;
              is_match_d  = 1'b1;
              cnt_d       = '0;
              state_d     = (limit == '0) ? S_DONE : S_SCAN;
            end
            OP_READ: begin
              ram_re     = 1'b1;
              is_match_d = 1'b0;
              rd_oob_d   = !idx_ok;
              state_d    = S_READ;
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        ram_re    = 1'b1;
        ram_raddr = cnt_q[AW-1:0];
        issue     = 1'b1;
        cnt_d     = cnt_q + CW'(1);
        if (cnt_q == limit - CW'(1)) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!rd_valid_q && !chain_busy) begin
          state_d = S_DONE;
        end
      end
      S_READ: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cnt_q      <= '0;
      is_match_q <= 1'b0;
      rd_oob_q   <= 1'b0;
      rd_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      is_match_q <= is_match_d;
      rd_oob_q   <= rd_oob_d;
      rd_valid_q <= issue;
    end
  end

  // Hold the query, tag each fetched entry with its index and capture the read result
  always_ff @(posedge clk_i) begin
    if (start_match) begin
      query_q <= in_color;
    end
    rd_index_q <= IDX_W'(cnt_q);
    if (state_q == S_READ) begin
      res_color_q <= rd_oob_q ? '0 : ram_rdata;
    end
  end

  pncm_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_ext[AW-1:0]),
    .wdata_i (in_color),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Row of channel cells: alpha, red, green, blue
  always_comb begin
    chain[0].valid    = rd_valid_q;
    chain[0].index    = rd_index_q;
    chain[0].color    = ram_rdata;
    chain[0].dist_sum = '0;
  end

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    pncm_cell #(
      .SHIFT (24 - 8 * k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .query_i (query_q),
      .cell_i  (chain[k]),
      .cell_o  (chain[k+1])
    );
  end

  assign chain_busy = chain[1].valid || chain[2].valid || chain[3].valid || chain[4].valid;

  // Keep the first strictly smaller distance at the end of the row
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q    <= 1'b0;
      best_d_q <= DIST_LIMIT;
      best_i_q <= '0;
    end else if (start_match) begin
      hit_q    <= 1'b0;
      best_d_q <= DIST_LIMIT;
      best_i_q <= '0;
    end else if (chain[NCELL].valid && (chain[NCELL].dist_sum < best_d_q)) begin
      hit_q    <= 1'b1;
      best_d_q <= chain[NCELL].dist_sum;
      best_i_q <= chain[NCELL].index;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (load_out) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  // Pack the result word
  always_comb begin
    m_data_d = '0;
    if (is_match_q) begin
      if (hit_q) begin
        m_data_d[IDX_W-1:0]         = best_i_q;
        m_data_d[IDX_W]             = 1'b1;
        m_data_d[IDX_W+1 +: DIST_W] = best_d_q;
      end
    end else begin
      m_data_d[IDX_W+1+DIST_W +: COLOR_W] = res_color_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      m_data_q <= m_data_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // The cell row is empty whenever a new request can be taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (!rd_valid_q && !chain_busy))
    else $error("cell row busy while idle");

  // A result without a hit carries zero index and distance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_data_q[IDX_W]) |->
      (m_data_q[IDX_W-1:0] == '0 && m_data_q[IDX_W+1 +: DIST_W] == '0))
    else $error("nothing found but index or distance nonzero");

  // A reported hit is always under the distance bound
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_data_q[IDX_W]) |-> (m_data_q[IDX_W+1 +: DIST_W] < DIST_LIMIT))
    else $error("reported distance not below bound");

endmodule

`default_nettype wire
